/* sv/hpd_pkg.sv */
package hpd_pkg;

	// Widths of the datapath
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int ATAN_IDX_W  = 5;
	localparam int VEC_W       = 27;
	localparam int PROD_W      = 34;
	localparam int ACC_W       = 35;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_THRESHOLD = 3'd5;

	// Configuration reset values
	localparam logic [15:0] RST_TARGET_X          = 16'd0;
	localparam logic [15:0] RST_TARGET_Y          = 16'd0;
	localparam logic [15:0] RST_PROP_GAIN         = 16'd32170;
	localparam logic [15:0] RST_DERIV_GAIN        = 16'd4021;
	localparam logic [14:0] RST_BASE_SPEED        = 15'd7680;
	localparam logic [14:0] RST_REVERSE_THRESHOLD = 15'd18022;

	// Half a turn in binary angle units
	localparam logic [15:0] HALF_TURN = 16'h8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_ERR,
		ST_MULP,
		ST_MULD,
		ST_SUM,
		ST_OUT
	} hpd_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic                  load;
		logic                  iter;
		logic [ATAN_IDX_W-1:0] iter_idx;
		logic                  err;
		logic                  mulp;
		logic                  muld;
		logic                  sum;
		logic                  out_load;
	} hpd_cmd_t;

	// Rounded atan(2^-i) in binary angle units
	function automatic logic [15:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0:    v = 16'd8192;
			5'd1:    v = 16'd4836;
			5'd2:    v = 16'd2555;
			5'd3:    v = 16'd1297;
			5'd4:    v = 16'd651;
			5'd5:    v = 16'd326;
			5'd6:    v = 16'd163;
			5'd7:    v = 16'd81;
			5'd8:    v = 16'd41;
			5'd9:    v = 16'd20;
			5'd10:   v = 16'd10;
			5'd11:   v = 16'd5;
			5'd12:   v = 16'd3;
			5'd13:   v = 16'd1;
			5'd14:   v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

/* sv/differential_drive_heading_pd.sv */
// An accepted pose runs through the iterative CORDIC unit, one vectoring step
// per cycle, then error, the shared multiplier (proportional, then derivative),
// sum and output load; a new pose is taken only once the controller is idle.
// Reset (arst_n low, asynchronous): controller idle, no result pending,
// configuration registers at their reset values, previous (derivative) error cleared.
module differential_drive_heading_pd #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             robot_x,
	input  logic signed [15:0]             robot_y,
	input  logic [15:0]                    robot_heading,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             left_speed,
	output logic signed [15:0]             right_speed,
	output logic                           reversed
);

	hpd_pkg::hpd_cmd_t cmd;

	// Sequence one transaction through the datapath
	hpd_ctrl #(
		.STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Bearing, error, PD term and wheel mapping
	hpd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.robot_x       (robot_x),
		.robot_y       (robot_y),
		.robot_heading (robot_heading),
		.cmd           (cmd),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.reversed      (reversed)
	);

endmodule

/* sv/hpd_ctrl.sv */
module hpd_ctrl #(
	parameter int STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             out_stall,
	output logic             out_valid,
	output hpd_pkg::hpd_cmd_t cmd
);

	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(STEPS - 1);

	hpd_pkg::hpd_state_t state_q, state_nx;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;

	assign accept   = in_valid && (state_q == hpd_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hpd_pkg::ST_IDLE: begin
				if (in_valid)
					state_nx = hpd_pkg::ST_ITER;
			end
			hpd_pkg::ST_ITER: begin
				if (cnt_q == LAST_ITER)
					state_nx = hpd_pkg::ST_ERR;
			end
			hpd_pkg::ST_ERR:  state_nx = hpd_pkg::ST_MULP;
			hpd_pkg::ST_MULP: state_nx = hpd_pkg::ST_MULD;
			hpd_pkg::ST_MULD: state_nx = hpd_pkg::ST_SUM;
			hpd_pkg::ST_SUM:  state_nx = hpd_pkg::ST_OUT;
			hpd_pkg::ST_OUT: begin
				if (out_free)
					state_nx = hpd_pkg::ST_IDLE;
			end
			default: state_nx = hpd_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.iter_idx = hpd_pkg::ATAN_IDX_W'(cnt_q);
		case (state_q)
			hpd_pkg::ST_IDLE: cmd.load     = accept;
			hpd_pkg::ST_ITER: cmd.iter     = 1'b1;
			hpd_pkg::ST_ERR:  cmd.err      = 1'b1;
			hpd_pkg::ST_MULP: cmd.mulp     = 1'b1;
			hpd_pkg::ST_MULD: cmd.muld     = 1'b1;
			hpd_pkg::ST_SUM:  cmd.sum      = 1'b1;
			hpd_pkg::ST_OUT:  cmd.out_load = out_free;
			default:          cmd          = '0;
		endcase
	end

	// Advance state, iteration count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hpd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == hpd_pkg::ST_ITER)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != hpd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* sv/hpd_datapath.sv */
module hpd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hpd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [15:0]                  robot_x,
	input  logic signed [15:0]                  robot_y,
	input  logic [15:0]                         robot_heading,
	input  hpd_pkg::hpd_cmd_t                   cmd,
	output logic signed [15:0]                  left_speed,
	output logic signed [15:0]                  right_speed,
	output logic                                reversed
);

	localparam int VW = hpd_pkg::VEC_W;

	// Configuration registers
	logic signed [15:0] target_x_q;
	logic signed [15:0] target_y_q;
	logic [15:0]        prop_gain_q;
	logic [15:0]        deriv_gain_q;
	logic [14:0]        base_speed_q;
	logic [14:0]        rev_thr_q;

	// Working registers
	logic signed [VW-1:0]                x_q, y_q;
	logic [15:0]                         z_q;
	logic                                zero_q;
	logic [15:0]                         heading_q;
	logic signed [15:0]                  err_q;
	logic                                rev_q;
	logic signed [15:0]                  last_err_q;
	logic signed [hpd_pkg::PROD_W-1:0]   prod_q;
	logic signed [hpd_pkg::ACC_W-1:0]    acc_q;
	logic signed [15:0]                  left_q, right_q;
	logic                                reversed_q;

	// Load signals
	logic signed [16:0]    dx, dy;
	logic signed [VW-1:0]  x0, y0;

	// Iteration signals
	logic signed [VW-1:0]  xs, ys;
	logic [15:0]           atan_v;

	// Error signals
	logic [15:0]           brg;
	logic [15:0]           e_raw;
	logic signed [16:0]    e_ext;
	logic [16:0]           e_mag;
	logic                  e_rev;

	// Multiplier signals
	logic signed [16:0]                mul_a, mul_b;
	logic signed [hpd_pkg::PROD_W-1:0] mul_p;

	// Output signals
	logic signed [18:0]    corr_raw;
	logic signed [18:0]    base19;
	logic signed [18:0]    corr19;
	logic signed [15:0]    corr;
	logic signed [15:0]    base16;
	logic signed [15:0]    left_nx, right_nx;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q   <= hpd_pkg::RST_TARGET_X;
			target_y_q   <= hpd_pkg::RST_TARGET_Y;
			prop_gain_q  <= hpd_pkg::RST_PROP_GAIN;
			deriv_gain_q <= hpd_pkg::RST_DERIV_GAIN;
			base_speed_q <= hpd_pkg::RST_BASE_SPEED;
			rev_thr_q    <= hpd_pkg::RST_REVERSE_THRESHOLD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hpd_pkg::CFG_TARGET_X:          target_x_q   <= cfg_data;
				hpd_pkg::CFG_TARGET_Y:          target_y_q   <= cfg_data;
				hpd_pkg::CFG_PROP_GAIN:         prop_gain_q  <= cfg_data;
				hpd_pkg::CFG_DERIV_GAIN:        deriv_gain_q <= cfg_data;
				hpd_pkg::CFG_BASE_SPEED:        base_speed_q <= cfg_data[14:0];
				hpd_pkg::CFG_REVERSE_THRESHOLD: rev_thr_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Form the target vector, scaled by 2^8; it is folded into the right half plane on load
	always_comb begin
		dx = 17'(target_x_q) - 17'(robot_x);
		dy = 17'(target_y_q) - 17'(robot_y);
		x0 = {{(VW - 25){dx[16]}}, dx, 8'd0};
		y0 = {{(VW - 25){dy[16]}}, dy, 8'd0};
	end

	// One vectoring step; arithmetic shift rounds toward minus infinity
	always_comb begin
		xs     = x_q >>> cmd.iter_idx;
		ys     = y_q >>> cmd.iter_idx;
		atan_v = hpd_pkg::atan_lut(cmd.iter_idx);
	end

	// Heading error and reversal decision
	always_comb begin
		brg   = zero_q ? 16'd0 : z_q;
		e_raw = heading_q - brg;
		e_ext = {e_raw[15], e_raw};
		e_mag = e_raw[15] ? 17'(-e_ext) : 17'(e_ext);
		e_rev = e_mag > {2'b00, rev_thr_q};
	end

	// Shared multiplier: proportional term, then derivative term
	always_comb begin
		if (cmd.muld) begin
			mul_a = {1'b0, deriv_gain_q};
			mul_b = 17'(err_q) - 17'(last_err_q);
		end else begin
			mul_a = {1'b0, prop_gain_q};
			mul_b = 17'(err_q);
		end
		mul_p = mul_a * mul_b;
	end

	// Scale, clamp and map the correction to wheel speeds
	always_comb begin
		corr_raw = acc_q[hpd_pkg::ACC_W-1:16];
		base19   = {4'd0, base_speed_q};
		if (corr_raw > base19)
			corr19 = base19;
		else if (corr_raw < -base19)
			corr19 = -base19;
		else
			corr19 = corr_raw;
		corr   = corr19[15:0];
		base16 = {1'b0, base_speed_q};
		if (!rev_q) begin
			if (corr > 16'sd0) begin
				left_nx  = base16;
				right_nx = base16 - corr;
			end else begin
				left_nx  = base16 + corr;
				right_nx = base16;
			end
		end else begin
			if (corr > 16'sd0) begin
				left_nx  = corr - base16;
				right_nx = -base16;
			end else begin
				left_nx  = -base16;
				right_nx = -base16 - corr;
			end
		end
	end

	// Hold the derivative history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_err_q <= '0;
		else if (cmd.muld)
			last_err_q <= err_q;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= dx[16] ? -x0 : x0;
			y_q       <= dx[16] ? -y0 : y0;
			z_q       <= dx[16] ? hpd_pkg::HALF_TURN : 16'd0;
			zero_q    <= (dx == 17'sd0) && (dy == 17'sd0);
			heading_q <= robot_heading;
		end else if (cmd.iter) begin
			if (!y_q[VW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end
		if (cmd.err) begin
			err_q <= e_rev ? {~e_raw[15], e_raw[14:0]} : e_raw;
			rev_q <= e_rev;
		end
		if (cmd.mulp || cmd.muld)
			prod_q <= mul_p;
		if (cmd.muld)
			acc_q <= hpd_pkg::ACC_W'(prod_q);
		else if (cmd.sum)
			acc_q <= acc_q + hpd_pkg::ACC_W'(prod_q);
		if (cmd.out_load) begin
			left_q     <= left_nx;
			right_q    <= right_nx;
			reversed_q <= rev_q;
		end
	end

	assign left_speed  = left_q;
	assign right_speed = right_q;
	assign reversed    = reversed_q;

endmodule

/* sv/hpd_checker.sv */
module hpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] left_speed,
	input logic signed [15:0] right_speed,
	input logic               reversed
);

	// One transaction at a time: the input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is in flight");

	// A new result appears only as the controller returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result appeared while the controller is busy");

	// Wheel signs follow the driving direction
	a_wheel_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reversed ? (left_speed <= 16'sd0 && right_speed <= 16'sd0)
			: (left_speed >= 16'sd0 && right_speed >= 16'sd0)))
		else $error("wheel speed sign disagrees with reversed flag");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(left_speed)
			&& $stable(right_speed) && $stable(reversed)))
		else $error("stalled result changed");

endmodule

bind differential_drive_heading_pd hpd_checker u_hpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.left_speed  (left_speed),
	.right_speed (right_speed),
	.reversed    (reversed)
);
